// File: design/gbu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbu_pkg
// shared constants, types and reciprocal tables for the bilinear upscaler
// ----------------------------------------------------------------------------
package gbu_pkg;

  // frame store geometry and scale range
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_SCALE  = 16;

  // field widths
  localparam int COORD_W = 12;
  localparam int PIX_W   = 8;
  localparam int SCALE_W = 5;
  localparam int DIM_W   = 9;
  localparam int LIM_W   = COORD_W + 1;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CH_W  = COL_W - 1;
  localparam int RH_W  = ROW_W - 1;

  // fraction (coordinate mod scale), weights and weighted sum
  localparam int FRAC_W = $clog2(MAX_SCALE);
  localparam int WT_W   = 2 * FRAC_W + 1;
  localparam int PROD_W = PIX_W + WT_W;
  localparam int SUM_W  = PIX_W + 2 * FRAC_W;

  // reciprocal tables: ceil(2^RX_SH / s) and ceil(2^R2_SH / s^2)
  localparam int RX_SH = 17;
  localparam int RX_W  = 18;
  localparam int R2_SH = 24;
  localparam int R2_W  = 25;

  localparam int PIX_MAX = 255;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int APB_W   = 32;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // input op codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic {
    JOB_LOAD,
    JOB_QUERY
  } job_kind_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } gbu_cfg_t;

  // one classified item, as queued for the back end
  typedef struct packed {
    job_kind_t          kind;
    logic               oor;
    logic [CH_W-1:0]    col_e;
    logic [CH_W-1:0]    col_o;
    logic [RH_W-1:0]    row_e;
    logic [RH_W-1:0]    row_o;
    logic               col_par;
    logic               row_par;
    logic               has_r;
    logic               has_d;
    logic [FRAC_W-1:0]  dx;
    logic [FRAC_W-1:0]  dy;
    logic [SCALE_W-1:0] scale;
    logic [PIX_W-1:0]   pixel;
  } gbu_job_t;

  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
    logic [SCALE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SCALE_W'(1);
    end else if (v > SCALE_W'(MAX_SCALE)) begin
      r = SCALE_W'(MAX_SCALE);
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // ceil(2^17 / s), exact quotient for any 12-bit coordinate and s <= 16
  function automatic logic [RX_W-1:0] recip_x(input logic [SCALE_W-1:0] s);
    logic [RX_W-1:0] r;
    case (s)
      5'd2:    r = RX_W'(65536);
      5'd3:    r = RX_W'(43691);
      5'd4:    r = RX_W'(32768);
      5'd5:    r = RX_W'(26215);
      5'd6:    r = RX_W'(21846);
      5'd7:    r = RX_W'(18725);
      5'd8:    r = RX_W'(16384);
      5'd9:    r = RX_W'(14564);
      5'd10:   r = RX_W'(13108);
      5'd11:   r = RX_W'(11916);
      5'd12:   r = RX_W'(10923);
      5'd13:   r = RX_W'(10083);
      5'd14:   r = RX_W'(9363);
      5'd15:   r = RX_W'(8739);
      5'd16:   r = RX_W'(8192);
      default: r = RX_W'(131072);
    endcase
    return r;
  endfunction

  // ceil(2^24 / s^2), exact quotient for any sum below 2^16
  function automatic logic [R2_W-1:0] recip_sq(input logic [SCALE_W-1:0] s);
    logic [R2_W-1:0] r;
    case (s)
      5'd2:    r = R2_W'(4194304);
      5'd3:    r = R2_W'(1864136);
      5'd4:    r = R2_W'(1048576);
      5'd5:    r = R2_W'(671089);
      5'd6:    r = R2_W'(466034);
      5'd7:    r = R2_W'(342393);
      5'd8:    r = R2_W'(262144);
      5'd9:    r = R2_W'(207127);
      5'd10:   r = R2_W'(167773);
      5'd11:   r = R2_W'(138655);
      5'd12:   r = R2_W'(116509);
      5'd13:   r = R2_W'(99274);
      5'd14:   r = R2_W'(85599);
      5'd15:   r = R2_W'(74566);
      5'd16:   r = R2_W'(65536);
      default: r = R2_W'(16777216);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/gbu_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbu_cfg
// register file behind the apb port, hands out clamped settings
// ----------------------------------------------------------------------------
module gbu_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gbu_pkg::PADDR_W-1:0] paddr,
  input  logic [gbu_pkg::APB_W-1:0]   pwdata,
  output logic [gbu_pkg::APB_W-1:0]   prdata,
  output logic                        pready,
  output gbu_pkg::gbu_cfg_t           cfg
);
  import gbu_pkg::*;

  typedef enum logic [1:0] {
    REG_SCALE  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  localparam logic [SCALE_W-1:0] SCALE_RST  = SCALE_W'(2);
  localparam logic [DIM_W-1:0]   WIDTH_RST  = DIM_W'(256);
  localparam logic [DIM_W-1:0]   HEIGHT_RST = DIM_W'(256);

  reg_idx_t           idx;
  logic               wr_en;
  logic [SCALE_W-1:0] scale_r, scale_nxt;
  logic [DIM_W-1:0]   width_r, width_nxt;
  logic [DIM_W-1:0]   height_r, height_nxt;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    scale_nxt  = scale_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    prdata     = '0;
    case (idx)
      REG_SCALE: begin
        prdata = APB_W'(scale_r);
        if (wr_en) scale_nxt = pwdata[SCALE_W-1:0];
      end
      REG_WIDTH: begin
        prdata = APB_W'(width_r);
        if (wr_en) width_nxt = pwdata[DIM_W-1:0];
      end
      REG_HEIGHT: begin
        prdata = APB_W'(height_r);
        if (wr_en) height_nxt = pwdata[DIM_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else begin
      scale_r  <= scale_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign cfg.scale  = clamp_scale(scale_r);
  assign cfg.width  = clamp_dim(width_r, DIM_W'(MAX_WIDTH));
  assign cfg.height = clamp_dim(height_r, DIM_W'(MAX_HEIGHT));

endmodule
`default_nettype wire

// File: design/gbu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbu_front
// accepts items, drops stray loads, splits coordinates into cell and fraction
// ----------------------------------------------------------------------------
module gbu_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gbu_pkg::gbu_cfg_t           cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [gbu_pkg::COORD_W-1:0] in_coord_x,
  input  logic [gbu_pkg::COORD_W-1:0] in_coord_y,
  input  logic [gbu_pkg::PIX_W-1:0]   in_pixel,
  input  logic                        full,
  output logic                        push,
  output gbu_pkg::gbu_job_t           job
);
  import gbu_pkg::*;

  localparam int PX_W = COORD_W + RX_W;

  logic               adv;
  logic [LIM_W-1:0]   lim_x, lim_y;
  logic               q_oor, load_ok;
  logic [PX_W-1:0]    prod_x, prod_y;

  // stage 1: range check and reciprocal multiply
  logic               f1_vld_r;
  logic               f1_op_r;
  logic               f1_oor_r;
  logic [COORD_W-1:0] f1_x_r, f1_y_r;
  logic [COORD_W-1:0] f1_qx_r, f1_qy_r;
  logic [SCALE_W-1:0] f1_s_r;
  logic [PIX_W-1:0]   f1_pix_r;

  // stage 2 combinational terms
  logic [COORD_W-1:0] back_x, back_y, rem_x, rem_y;
  logic [COL_W-1:0]   px;
  logic [ROW_W-1:0]   py;
  logic [COL_W:0]     px1;
  logic [ROW_W:0]     py1;

  logic               f2_vld_r;
  gbu_job_t           job_r;

  assign adv      = !(f2_vld_r && full);
  assign in_ready = adv;
  assign push     = f2_vld_r && !full;
  assign job      = job_r;

  assign lim_x   = LIM_W'(cfg.width) * LIM_W'(cfg.scale);
  assign lim_y   = LIM_W'(cfg.height) * LIM_W'(cfg.scale);
  assign q_oor   = (LIM_W'(in_coord_x) >= lim_x) || (LIM_W'(in_coord_y) >= lim_y);
  assign load_ok = (in_coord_x < COORD_W'(cfg.width)) && (in_coord_y < COORD_W'(cfg.height));
  assign prod_x  = PX_W'(in_coord_x) * PX_W'(recip_x(cfg.scale));
  assign prod_y  = PX_W'(in_coord_y) * PX_W'(recip_x(cfg.scale));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r <= in_valid && ((in_op == OP_QUERY) || load_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_op_r  <= in_op;
      f1_oor_r <= (in_op == OP_QUERY) && q_oor;
      f1_x_r   <= in_coord_x;
      f1_y_r   <= in_coord_y;
      f1_qx_r  <= prod_x[RX_SH +: COORD_W];
      f1_qy_r  <= prod_y[RX_SH +: COORD_W];
      f1_s_r   <= cfg.scale;
      f1_pix_r <= in_pixel;
    end
  end

  // stage 2: remainder, neighbor clamp, bank addresses
  assign back_x = f1_qx_r * COORD_W'(f1_s_r);
  assign back_y = f1_qy_r * COORD_W'(f1_s_r);
  assign rem_x  = f1_x_r - back_x;
  assign rem_y  = f1_y_r - back_y;

  // a load addresses its own pixel, a query the top-left corner of its cell
  assign px  = (f1_op_r == OP_QUERY) ? f1_qx_r[COL_W-1:0] : f1_x_r[COL_W-1:0];
  assign py  = (f1_op_r == OP_QUERY) ? f1_qy_r[ROW_W-1:0] : f1_y_r[ROW_W-1:0];
  assign px1 = (COL_W+1)'(px) + (COL_W+1)'(1);
  assign py1 = (ROW_W+1)'(py) + (ROW_W+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else if (adv) begin
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job_r.kind    <= (f1_op_r == OP_QUERY) ? JOB_QUERY : JOB_LOAD;
      job_r.oor     <= f1_oor_r;
      job_r.col_e   <= px1[CH_W:1];
      job_r.col_o   <= px[COL_W-1:1];
      job_r.row_e   <= py1[RH_W:1];
      job_r.row_o   <= py[ROW_W-1:1];
      job_r.col_par <= px[0];
      job_r.row_par <= py[0];
      job_r.has_r   <= (DIM_W'(px) + DIM_W'(1)) < cfg.width;
      job_r.has_d   <= (DIM_W'(py) + DIM_W'(1)) < cfg.height;
      job_r.dx      <= rem_x[FRAC_W-1:0];
      job_r.dy      <= rem_y[FRAC_W-1:0];
      job_r.scale   <= f1_s_r;
      job_r.pixel   <= f1_pix_r;
    end
  end

endmodule
`default_nettype wire

// File: design/gbu_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbu_fifo
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module gbu_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gbu_pkg::gbu_job_t din,
  output logic              full,
  input  logic              pop,
  output gbu_pkg::gbu_job_t dout,
  output logic              empty
);
  import gbu_pkg::*;

  gbu_job_t           slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  assign full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign dout  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      if (push && !pop) begin
        count_r <= count_r + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: design/gbu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbu_back
// four-bank frame store, weighting, sum and divide by scale squared
// ----------------------------------------------------------------------------
module gbu_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      empty,
  input  gbu_pkg::gbu_job_t         job,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [gbu_pkg::PIX_W-1:0] out_value,
  output logic                      out_out_of_range
);
  import gbu_pkg::*;

  localparam int NBANK      = 4;
  localparam int BANK_AW    = RH_W + CH_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int QP_W       = SUM_W + R2_W;
  localparam int QUO_W      = QP_W - R2_SH;

  logic adv;

  // stage 1: bank reads and weights
  logic               b1_vld_r;
  logic [PIX_W-1:0]   rd_r [NBANK];
  logic [WT_W-1:0]    b1_wt_r [NBANK];
  logic               b1_cp_r, b1_rp_r, b1_hr_r, b1_hd_r, b1_oor_r;
  logic [SCALE_W-1:0] b1_s_r;
  logic [SCALE_W-1:0] wx0, wx1, wy0, wy1;

  // stage 2: products
  logic               b2_vld_r;
  logic [SUM_W-1:0]   b2_m_r [NBANK];
  logic               b2_oor_r;
  logic [SCALE_W-1:0] b2_s_r;
  logic [PIX_W-1:0]   t_e, t_o, d_e, d_o;
  logic [PIX_W-1:0]   p00, p01, p10, p11;
  logic [PROD_W-1:0]  m00, m01, m10, m11;

  // stage 3: sum
  logic               b3_vld_r;
  logic [SUM_W-1:0]   b3_sum_r;
  logic               b3_oor_r;
  logic [SCALE_W-1:0] b3_s_r;

  logic [QP_W-1:0]    qprod;
  logic [QUO_W-1:0]   quo;
  logic [PIX_W-1:0]   val;

  logic               out_vld_r, out_oor_r;
  logic [PIX_W-1:0]   out_val_r;

  assign adv = !out_vld_r || out_ready;
  assign pop = adv && !empty;

  // banks by row and column parity, so any 2x2 cell hits each bank once
  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    localparam bit ROW_ODD = (b >= 2);
    localparam bit COL_ODD = ((b % 2) == 1);
    logic [PIX_W-1:0]   mem [BANK_DEPTH];
    logic [BANK_AW-1:0] addr;
    logic               we;

    assign addr = {(ROW_ODD ? job.row_o : job.row_e), (COL_ODD ? job.col_o : job.col_e)};
    assign we   = (job.kind == JOB_LOAD) && (job.row_par == ROW_ODD)
                  && (job.col_par == COL_ODD);

    always_ff @(posedge clk) begin
      if (pop) begin
        if (we) mem[addr] <= job.pixel;
        rd_r[b] <= mem[addr];
      end
    end
  end

  assign wx0 = job.scale - SCALE_W'(job.dx);
  assign wx1 = SCALE_W'(job.dx);
  assign wy0 = job.scale - SCALE_W'(job.dy);
  assign wy1 = SCALE_W'(job.dy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
      b2_vld_r <= 1'b0;
      b3_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      b1_vld_r  <= pop && (job.kind == JOB_QUERY);
      b2_vld_r  <= b1_vld_r;
      b3_vld_r  <= b2_vld_r;
      out_vld_r <= b3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_wt_r[0] <= WT_W'(wx0) * WT_W'(wy0);
      b1_wt_r[1] <= WT_W'(wx1) * WT_W'(wy0);
      b1_wt_r[2] <= WT_W'(wx0) * WT_W'(wy1);
      b1_wt_r[3] <= WT_W'(wx1) * WT_W'(wy1);
      b1_cp_r    <= job.col_par;
      b1_rp_r    <= job.row_par;
      b1_hr_r    <= job.has_r;
      b1_hd_r    <= job.has_d;
      b1_oor_r   <= job.oor;
      b1_s_r     <= job.scale;
    end
  end

  // line up banks as top/bottom row and even/odd column, clamp at the edges
  always_comb begin
    t_e = b1_rp_r ? rd_r[2] : rd_r[0];
    t_o = b1_rp_r ? rd_r[3] : rd_r[1];
    d_e = b1_rp_r ? rd_r[0] : rd_r[2];
    d_o = b1_rp_r ? rd_r[1] : rd_r[3];
    if (!b1_hd_r) begin
      d_e = t_e;
      d_o = t_o;
    end
    p00 = b1_cp_r ? t_o : t_e;
    p10 = b1_cp_r ? d_o : d_e;
    p01 = b1_hr_r ? (b1_cp_r ? t_e : t_o) : p00;
    p11 = b1_hr_r ? (b1_cp_r ? d_e : d_o) : p10;
  end

  assign m00 = PROD_W'(p00) * PROD_W'(b1_wt_r[0]);
  assign m01 = PROD_W'(p01) * PROD_W'(b1_wt_r[1]);
  assign m10 = PROD_W'(p10) * PROD_W'(b1_wt_r[2]);
  assign m11 = PROD_W'(p11) * PROD_W'(b1_wt_r[3]);

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_m_r[0] <= m00[SUM_W-1:0];
      b2_m_r[1] <= m01[SUM_W-1:0];
      b2_m_r[2] <= m10[SUM_W-1:0];
      b2_m_r[3] <= m11[SUM_W-1:0];
      b2_oor_r  <= b1_oor_r;
      b2_s_r    <= b1_s_r;
      b3_sum_r  <= b2_m_r[0] + b2_m_r[1] + b2_m_r[2] + b2_m_r[3];
      b3_oor_r  <= b2_oor_r;
      b3_s_r    <= b2_s_r;
    end
  end

  // divide by scale squared through the reciprocal table
  assign qprod = QP_W'(b3_sum_r) * QP_W'(recip_sq(b3_s_r));
  assign quo   = qprod[QP_W-1:R2_SH];
  assign val   = (quo > QUO_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : quo[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (adv && b3_vld_r) begin
      out_val_r <= b3_oor_r ? '0 : val;
      out_oor_r <= b3_oor_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_value        = out_val_r;
  assign out_out_of_range = out_oor_r;

endmodule
`default_nettype wire

// File: design/gray_bilinear_upscale.sv
// a query's result passes the front stages, the queue, the back stages and the output register
// throughput: one item per cycle while the result side does not stall, loads and queries alike; loads give no result
// the rate is set by the single-port write/read of each of the four frame store banks
// reset: synchronous, active low; clears the pipeline, the queue and the registers
// the frame store is not cleared: no clearing pass, the block is ready right after reset
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gray_bilinear_upscale
// grayscale integer-factor upscaler with bilinear interpolation over a
// loaded source frame
// ----------------------------------------------------------------------------
module gray_bilinear_upscale (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [gbu_pkg::COORD_W-1:0] in_coord_x,
  input  logic [gbu_pkg::COORD_W-1:0] in_coord_y,
  input  logic [gbu_pkg::PIX_W-1:0]   in_pixel,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gbu_pkg::PIX_W-1:0]   out_value,
  output logic                        out_out_of_range,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gbu_pkg::PADDR_W-1:0] paddr,
  input  logic [gbu_pkg::APB_W-1:0]   pwdata,
  output logic [gbu_pkg::APB_W-1:0]   prdata,
  output logic                        pready
);
  import gbu_pkg::*;

  gbu_cfg_t cfg;
  gbu_job_t fe_job, q_job;
  logic     q_push, q_full, q_pop, q_empty;

  // register file: scale, source width and height, clamped to their ranges
  gbu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front: two stages; range check and cell/fraction split by reciprocal
  // multiply, loads outside the source frame are dropped here
  gbu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .in_pixel   (in_pixel),
    .full       (q_full),
    .push       (q_push),
    .job        (fe_job)
  );

  // queue: the front keeps taking transfers while the result side stalls, until the queue is full
  gbu_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (fe_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_job),
    .empty (q_empty)
  );

  // back: loads write the banked store in order with queries, so a query
  // always sees every load taken before it; results leave via a register
  gbu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .empty            (q_empty),
    .job              (q_job),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_value        (out_value),
    .out_out_of_range (out_out_of_range)
  );

endmodule
`default_nettype wire

// File: design/gbu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbu_checker
// port-level checks on the upscaler's result channel and reset behavior
// ----------------------------------------------------------------------------
module gbu_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [gbu_pkg::PIX_W-1:0] out_value,
  input logic                      out_out_of_range
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_out_of_range))
    else $error("result changed while stalled");

  // out-of-range queries give a zero value
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_value == '0)
    else $error("out-of-range result with nonzero value");

  // reset empties the pipeline and opens the input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind gray_bilinear_upscale gbu_checker u_gbu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_value        (out_value),
  .out_out_of_range (out_out_of_range)
);
`default_nettype wire
